FILE: hdl/im2col_scatter_index_generator_assert.svh
// assertion macros for the checker file
`ifndef IM2COL_SCATTER_INDEX_GENERATOR_ASSERT_SVH
`define IM2COL_SCATTER_INDEX_GENERATOR_ASSERT_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define ISIG_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("isig assertion failed");

// assertion on the block clock and reset
`define ISIG_ASSERT(label, prop) `ISIG_ASSERT_CLK(label, i_clk, i_rst_n, prop)

`endif

FILE: hdl/isig_pkg.sv
package isig_pkg;

    // field and register widths
    localparam int DIM_W      = 13;
    localparam int QS_W       = DIM_W + 1;
    localparam int KER_W      = 4;
    localparam int KC_W       = 3;
    localparam int BATCH_W    = 8;
    localparam int CHAN_W     = 10;
    localparam int PIX_W      = 32;
    localparam int KOFF_W     = 6;
    localparam int WPOS_W     = 24;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int DIV_CNT_W  = 4;

    // saturation limits
    localparam int MAX_DIM    = 4096;
    localparam int MAX_KERNEL = 8;

    // register map index
    typedef enum logic [2:0] {
        REG_IMAGE_HEIGHT = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_PAD_ROWS     = 3'd2,
        REG_PAD_COLS     = 3'd3,
        REG_KERNEL_ROWS  = 3'd4,
        REG_KERNEL_COLS  = 3'd5,
        REG_STRIDE_ROWS  = 3'd6,
        REG_STRIDE_COLS  = 3'd7
    } t_reg_idx;

    // configuration register set
    typedef struct packed {
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] image_width;
        logic [KER_W-1:0] pad_rows;
        logic [KER_W-1:0] pad_cols;
        logic [KER_W-1:0] kernel_rows;
        logic [KER_W-1:0] kernel_cols;
        logic [KER_W-1:0] stride_rows;
        logic [KER_W-1:0] stride_cols;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic            capture;
        logic            load;
        logic            step;
        logic            flush;
        logic [KC_W-1:0] kc;
        logic [KC_W-1:0] kr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic kzero;
        logic stall;
        logic col_hit;
        logic row_end;
        logic col_end;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/isig_div.sv
module isig_div import isig_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIM_W-1:0] i_dividend,
    input  logic [KER_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIM_W-1:0] o_quot,
    output logic [KER_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_num;
    logic [KER_W-1:0]     r_den;
    logic [KER_W-1:0]     r_rem;
    logic [KER_W:0]       n_trial;
    logic                 n_ge;
    logic [KER_W-1:0]     n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_num[DIM_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_rem   = n_ge ? KER_W'(n_trial - {1'b0, r_den}) : KER_W'(n_trial);
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIM_W-2:0], n_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/isig_ctrl.sv
module isig_ctrl import isig_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state          r_state;
    logic            r_in_ready;
    logic [KC_W-1:0] r_kc;
    logic [KC_W-1:0] r_kr;

    // commands to the datapath
    always_comb begin
        o_cmd         = '0;
        o_cmd.kc      = r_kc;
        o_cmd.kr      = r_kr;
        o_cmd.capture = (r_state == S_IDLE) && i_valid && r_in_ready;
        o_cmd.load    = (r_state == S_DIV) && i_sts.div_done;
        o_cmd.step    = (r_state == S_SCAN) && !i_sts.stall;
        o_cmd.flush   = (r_state == S_FLUSH) && i_sts.out_free;
    end

    // state, kernel counters and input ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
            r_kc       <= '0;
            r_kr       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && r_in_ready) begin
                        r_state    <= S_DIV;
                        r_in_ready <= 1'b0;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_kc    <= '0;
                        r_kr    <= '0;
                        r_state <= i_sts.kzero ? S_FLUSH : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!i_sts.stall) begin
                        if (i_sts.col_hit && !i_sts.row_end) begin
                            r_kr <= r_kr + 1'b1;
                        end else begin
                            r_kr <= '0;
                            r_kc <= r_kc + 1'b1;
                            if (i_sts.col_end) begin
                                r_state <= S_FLUSH;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (!i_sts.pend_valid || i_sts.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready = r_in_ready;

endmodule

FILE: hdl/isig_dp.sv
module isig_dp import isig_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [BATCH_W-1:0] i_batch_index,
    input  logic [CHAN_W-1:0]  i_channel_index,
    input  logic [DIM_W-1:0]   i_padded_row,
    input  logic [DIM_W-1:0]   i_padded_col,
    input  logic [PIX_W-1:0]   i_pixel_bits,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [BATCH_W-1:0] o_out_batch,
    output logic [CHAN_W-1:0]  o_out_channel,
    output logic [KOFF_W-1:0]  o_kernel_offset,
    output logic [WPOS_W-1:0]  o_window_position,
    output logic [PIX_W-1:0]   o_element_bits,
    output logic               o_last
);

    localparam int NUM_LANES = 4;
    localparam int LANE_ROW  = 0;
    localparam int LANE_COL  = 1;
    localparam int LANE_OH   = 2;
    localparam int LANE_OW   = 3;

    // window index tracker: floor quotient and remainder of (pos - k) / stride
    typedef struct packed {
        logic [QS_W-1:0]  q;
        logic [KER_W-1:0] rem;
    } t_trk;

    function automatic t_trk trk_dec(t_trk t, logic [KER_W-1:0] s);
        t_trk n;
        n = t;
        if (t.rem == '0) begin
            n.rem = s - 1'b1;
            n.q   = t.q - 1'b1;
        end else begin
            n.rem = t.rem - 1'b1;
        end
        return n;
    endfunction

    logic [DIM_W-1:0]     h, w, oh, ow;
    logic [KER_W-1:0]     kh, kw, sh, sw;
    logic [QS_W-1:0]      ph, pw, row_hi, col_hi;
    logic                 ok_h, ok_w, in_pad;
    logic [DIM_W-1:0]     div_num [NUM_LANES];
    logic [KER_W-1:0]     div_den [NUM_LANES];
    logic [DIM_W-1:0]     div_q   [NUM_LANES];
    logic [KER_W-1:0]     div_r   [NUM_LANES];
    logic [NUM_LANES-1:0] div_done;

    logic [BATCH_W-1:0] r_batch;
    logic [CHAN_W-1:0]  r_chan;
    logic [PIX_W-1:0]   r_ebits;
    t_trk               r_col, r_row, row_init;
    logic               col_hit, row_hit, hit, row_end, col_end, out_free, stall;
    logic [6:0]         koff_full;
    logic [2*DIM_W-1:0] wpos_full;

    logic               r_pend_valid;
    logic [KOFF_W-1:0]  r_pend_koff;
    logic [WPOS_W-1:0]  r_pend_wpos;
    logic               r_out_valid;
    logic               load_mid, load_fin;

    // effective geometry after saturation
    always_comb begin
        h  = (i_cfg.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.image_height;
        w  = (i_cfg.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.image_width;
        kh = (i_cfg.kernel_rows > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL)
                                                      : i_cfg.kernel_rows;
        kw = (i_cfg.kernel_cols > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL)
                                                      : i_cfg.kernel_cols;
        sh = (i_cfg.stride_rows == '0) ? KER_W'(1) : i_cfg.stride_rows;
        sw = (i_cfg.stride_cols == '0) ? KER_W'(1) : i_cfg.stride_cols;
        ph = {1'b0, h} + QS_W'({i_cfg.pad_rows, 1'b0});
        pw = {1'b0, w} + QS_W'({i_cfg.pad_cols, 1'b0});
        ok_h = (kh != '0) && (ph >= QS_W'(kh));
        ok_w = (kw != '0) && (pw >= QS_W'(kw));
        oh = ok_h ? div_q[LANE_OH] + 1'b1 : '0;
        ow = ok_w ? div_q[LANE_OW] + 1'b1 : '0;
    end

    // pad border test on the incoming element
    always_comb begin
        row_hi = QS_W'(i_cfg.pad_rows) + QS_W'(h);
        col_hi = QS_W'(i_cfg.pad_cols) + QS_W'(w);
        in_pad = (i_padded_row < DIM_W'(i_cfg.pad_rows)) || ({1'b0, i_padded_row} >= row_hi)
              || (i_padded_col < DIM_W'(i_cfg.pad_cols)) || ({1'b0, i_padded_col} >= col_hi);
    end

    // divider lanes: element row, element column, output height and width
    always_comb begin
        div_num[LANE_ROW] = i_padded_row;
        div_den[LANE_ROW] = sh;
        div_num[LANE_COL] = i_padded_col;
        div_den[LANE_COL] = sw;
        div_num[LANE_OH]  = DIM_W'(ph - QS_W'(kh));
        div_den[LANE_OH]  = sh;
        div_num[LANE_OW]  = DIM_W'(pw - QS_W'(kw));
        div_den[LANE_OW]  = sw;
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_div
        isig_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_cmd.capture),
            .i_dividend (div_num[g]),
            .i_divisor  (div_den[g]),
            .o_done     (div_done[g]),
            .o_quot     (div_q[g]),
            .o_rem      (div_r[g])
        );
    end

    // held item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_batch <= i_batch_index;
            r_chan  <= i_channel_index;
            r_ebits <= in_pad ? '0 : i_pixel_bits;
        end
    end

    // coverage tests for the current kernel column and row
    always_comb begin
        row_init.q   = {1'b0, div_q[LANE_ROW]};
        row_init.rem = div_r[LANE_ROW];
        col_hit  = (r_col.rem == '0) && !r_col.q[QS_W-1] && (r_col.q[DIM_W-1:0] < ow);
        row_hit  = (r_row.rem == '0) && !r_row.q[QS_W-1] && (r_row.q[DIM_W-1:0] < oh);
        hit      = col_hit && row_hit;
        col_end  = {1'b0, i_cmd.kc} == (kw - 1'b1);
        row_end  = {1'b0, i_cmd.kr} == (kh - 1'b1);
        out_free = !r_out_valid || i_out_ready;
        stall    = hit && r_pend_valid && !out_free;
    end

    // step the trackers along the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col.q   <= {1'b0, div_q[LANE_COL]};
            r_col.rem <= div_r[LANE_COL];
            r_row     <= row_init;
        end else if (i_cmd.step) begin
            if (col_hit && !row_end) begin
                r_row <= trk_dec(r_row, sh);
            end else begin
                r_col <= trk_dec(r_col, sw);
                r_row <= row_init;
            end
        end
    end

    // result coordinates
    always_comb begin
        koff_full = 7'(i_cmd.kr) * 7'(kw) + 7'(i_cmd.kc);
        wpos_full = (2*DIM_W)'(r_row.q[DIM_W-1:0]) * (2*DIM_W)'(ow)
                  + (2*DIM_W)'(r_col.q[DIM_W-1:0]);
    end

    // one-deep pending stage so the final result can be flagged
    assign load_mid = i_cmd.step && hit && r_pend_valid;
    assign load_fin = i_cmd.flush && r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && hit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && hit) begin
            r_pend_koff <= koff_full[KOFF_W-1:0];
            r_pend_wpos <= wpos_full[WPOS_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_mid || load_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_mid || load_fin) begin
            o_out_batch       <= r_batch;
            o_out_channel     <= r_chan;
            o_kernel_offset   <= r_pend_koff;
            o_window_position <= r_pend_wpos;
            o_element_bits    <= r_ebits;
            o_last            <= load_fin;
        end
    end

    assign o_out_valid = r_out_valid;

    // status to the controller
    always_comb begin
        o_sts            = '0;
        o_sts.div_done   = &div_done;
        o_sts.kzero      = (kw == '0) || (kh == '0);
        o_sts.stall      = stall;
        o_sts.col_hit    = col_hit;
        o_sts.row_end    = row_end;
        o_sts.col_end    = col_end;
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end

endmodule

FILE: hdl/im2col_scatter_index_generator.sv
// from acceptance of one input element until the next can be taken, the block runs the capture,
// the 13-step serial divide of row, column and extents, the scan and the flush; the scan steps
// through every kernel column, and through the kernel rows only where that column covers the
// element; the scan and the final flush also wait while a full output register is held off
// by the receiver; the first result leaves the pending stage on a second covering step or flush
// reset (synchronous, active low) empties the block and loads the default geometry
module im2col_scatter_index_generator import isig_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [BATCH_W-1:0] i_batch_index,
    input  logic [CHAN_W-1:0]  i_channel_index,
    input  logic [DIM_W-1:0]   i_padded_row,
    input  logic [DIM_W-1:0]   i_padded_col,
    input  logic [PIX_W-1:0]   i_pixel_bits,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BATCH_W-1:0] o_out_batch,
    output logic [CHAN_W-1:0]  o_out_channel,
    output logic [KOFF_W-1:0]  o_kernel_offset,
    output logic [WPOS_W-1:0]  o_window_position,
    output logic [PIX_W-1:0]   o_element_bits,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_sts     sts;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height <= DIM_W'(1);
            r_cfg.image_width  <= DIM_W'(1);
            r_cfg.pad_rows     <= '0;
            r_cfg.pad_cols     <= '0;
            r_cfg.kernel_rows  <= KER_W'(1);
            r_cfg.kernel_cols  <= KER_W'(1);
            r_cfg.stride_rows  <= KER_W'(1);
            r_cfg.stride_cols  <= KER_W'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[DIM_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[DIM_W-1:0];
                REG_PAD_ROWS:     r_cfg.pad_rows     <= pwdata[KER_W-1:0];
                REG_PAD_COLS:     r_cfg.pad_cols     <= pwdata[KER_W-1:0];
                REG_KERNEL_ROWS:  r_cfg.kernel_rows  <= pwdata[KER_W-1:0];
                REG_KERNEL_COLS:  r_cfg.kernel_cols  <= pwdata[KER_W-1:0];
                REG_STRIDE_ROWS:  r_cfg.stride_rows  <= pwdata[KER_W-1:0];
                REG_STRIDE_COLS:  r_cfg.stride_cols  <= pwdata[KER_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            REG_IMAGE_HEIGHT: prdata = DATA_W'(r_cfg.image_height);
            REG_IMAGE_WIDTH:  prdata = DATA_W'(r_cfg.image_width);
            REG_PAD_ROWS:     prdata = DATA_W'(r_cfg.pad_rows);
            REG_PAD_COLS:     prdata = DATA_W'(r_cfg.pad_cols);
            REG_KERNEL_ROWS:  prdata = DATA_W'(r_cfg.kernel_rows);
            REG_KERNEL_COLS:  prdata = DATA_W'(r_cfg.kernel_cols);
            REG_STRIDE_ROWS:  prdata = DATA_W'(r_cfg.stride_rows);
            REG_STRIDE_COLS:  prdata = DATA_W'(r_cfg.stride_cols);
            default:          prdata = '0;
        endcase
    end

    // sequencer
    isig_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // dividers, window trackers and result registers
    isig_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_batch_index     (i_batch_index),
        .i_channel_index   (i_channel_index),
        .i_padded_row      (i_padded_row),
        .i_padded_col      (i_padded_col),
        .i_pixel_bits      (i_pixel_bits),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_out_batch       (o_out_batch),
        .o_out_channel     (o_out_channel),
        .o_kernel_offset   (o_kernel_offset),
        .o_window_position (o_window_position),
        .o_element_bits    (o_element_bits),
        .o_last            (o_last)
    );

endmodule

FILE: hdl/isig_checker.sv
`include "im2col_scatter_index_generator_assert.svh"

module isig_checker import isig_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_last,
    input logic [WPOS_W-1:0] o_window_position
);

    // a request that is not taken stays on the port
    `ISIG_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid)

    // a stalled result keeps its coordinates and flag
    `ISIG_ASSERT(a_out_stable, o_valid && !i_ready |=> $stable(o_window_position) && $stable(o_last))

    // one element at a time: ready drops right after a request is taken
    `ISIG_ASSERT(a_in_single, i_valid && o_ready |=> !o_ready)

    // while a fan-out is still open no new element is taken
    `ISIG_ASSERT(a_open_fanout, o_valid && !o_last |-> !o_ready)

endmodule

bind im2col_scatter_index_generator isig_checker u_isig_checker (.*);

FILE: tb/sv/im2col_scatter_index_generator_test.sv
`timescale 1ns / 100ps

module im2col_scatter_index_generator_test;
    import isig_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 96;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 16;

    // one column-matrix coordinate as the block emits it
    typedef struct {
        logic [BATCH_W-1:0] batch;
        logic [CHAN_W-1:0]  channel;
        logic [KOFF_W-1:0]  kernel_offset;
        logic [WPOS_W-1:0]  window_position;
        logic [PIX_W-1:0]   element_bits;
        logic               last;
    } t_coord;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [BATCH_W-1:0] i_batch_index = '0;
    logic [CHAN_W-1:0]  i_channel_index = '0;
    logic [DIM_W-1:0]   i_padded_row = '0;
    logic [DIM_W-1:0]   i_padded_col = '0;
    logic [PIX_W-1:0]   i_pixel_bits = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [BATCH_W-1:0] o_out_batch;
    logic [CHAN_W-1:0]  o_out_channel;
    logic [KOFF_W-1:0]  o_kernel_offset;
    logic [WPOS_W-1:0]  o_window_position;
    logic [PIX_W-1:0]   o_element_bits;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // geometry as last written, reset values to start
    logic [DIM_W-1:0] cfg_height = 1;
    logic [DIM_W-1:0] cfg_width = 1;
    logic [KER_W-1:0] cfg_pad_rows = 0;
    logic [KER_W-1:0] cfg_pad_cols = 0;
    logic [KER_W-1:0] cfg_kernel_rows = 1;
    logic [KER_W-1:0] cfg_kernel_cols = 1;
    logic [KER_W-1:0] cfg_stride_rows = 1;
    logic [KER_W-1:0] cfg_stride_cols = 1;

    t_coord expected_coords[$];
    int     error_count = 0;
    int     coords_seen = 0;
    int     send_gap_pct = 36;
    int     ready_gap_pct = 36;
    logic   hold_token = 1'b0;
    logic   hold_seen = 1'b0;
    int     hold_left = 0;
    int     stall_cycles = 0;

    im2col_scatter_index_generator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_batch_index(i_batch_index),
        .i_channel_index(i_channel_index),
        .i_padded_row(i_padded_row),
        .i_padded_col(i_padded_col),
        .i_pixel_bits(i_pixel_bits),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_out_batch(o_out_batch),
        .o_out_channel(o_out_channel),
        .o_kernel_offset(o_kernel_offset),
        .o_window_position(o_window_position),
        .o_element_bits(o_element_bits),
        .o_last(o_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned clip(input int unsigned v, input int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // number of window positions along one axis
    function automatic int unsigned out_span(input int unsigned padded, input int unsigned k,
                                             input int unsigned s);
        if (k == 0 || padded < k) return 0;
        return (padded - k) / s + 1;
    endfunction

    // fan one element out into the coordinates of every window covering it
    function automatic void predict_scatter(input logic [BATCH_W-1:0] b,
                                            input logic [CHAN_W-1:0] ch,
                                            input logic [DIM_W-1:0] r,
                                            input logic [DIM_W-1:0] c,
                                            input logic [PIX_W-1:0] pix);
        int unsigned h, w, kh, kw, sh, sw, oh, ow, kc, kr, orow, ocol;
        logic [PIX_W-1:0] value;
        t_coord prev;
        bit have_prev;
        h  = clip(cfg_height, MAX_DIM);
        w  = clip(cfg_width, MAX_DIM);
        kh = clip(cfg_kernel_rows, MAX_KERNEL);
        kw = clip(cfg_kernel_cols, MAX_KERNEL);
        sh = (cfg_stride_rows == 0) ? 1 : cfg_stride_rows;
        sw = (cfg_stride_cols == 0) ? 1 : cfg_stride_cols;
        oh = out_span(h + 2 * cfg_pad_rows, kh, sh);
        ow = out_span(w + 2 * cfg_pad_cols, kw, sw);
        // pad border reads as zero
        if (r < cfg_pad_rows || r >= cfg_pad_rows + h || c < cfg_pad_cols
                || c >= cfg_pad_cols + w) begin
            value = '0;
        end else begin
            value = pix;
        end
        have_prev = 0;
        for (kc = 0; kc < kw; kc++) begin
            if (c < kc || (c - kc) % sw != 0) continue;
            ocol = (c - kc) / sw;
            if (ocol >= ow) continue;
            for (kr = 0; kr < kh; kr++) begin
                if (r < kr || (r - kr) % sh != 0) continue;
                orow = (r - kr) / sh;
                if (orow >= oh) continue;
                if (have_prev) expected_coords.push_back(prev);
                prev.batch           = b;
                prev.channel         = ch;
                prev.kernel_offset   = KOFF_W'(kr * kw + kc);
                prev.window_position = WPOS_W'(orow * ow + ocol);
                prev.element_bits    = value;
                prev.last            = 1'b0;
                have_prev = 1;
            end
        end
        // final coordinate of the fan-out carries last
        if (have_prev) begin
            prev.last = 1'b1;
            expected_coords.push_back(prev);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // one register write: setup then access
    task automatic write_reg(input t_reg_idx idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_HEIGHT: cfg_height = value[DIM_W-1:0];
            REG_IMAGE_WIDTH:  cfg_width = value[DIM_W-1:0];
            REG_PAD_ROWS:     cfg_pad_rows = value[KER_W-1:0];
            REG_PAD_COLS:     cfg_pad_cols = value[KER_W-1:0];
            REG_KERNEL_ROWS:  cfg_kernel_rows = value[KER_W-1:0];
            REG_KERNEL_COLS:  cfg_kernel_cols = value[KER_W-1:0];
            REG_STRIDE_ROWS:  cfg_stride_rows = value[KER_W-1:0];
            REG_STRIDE_COLS:  cfg_stride_cols = value[KER_W-1:0];
            default: ;
        endcase
    endtask

    // drop valid, wait for every coordinate, then let the block settle
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (expected_coords.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned h, input int unsigned w,
                                input int unsigned pr, input int unsigned pc,
                                input int unsigned kr, input int unsigned kc,
                                input int unsigned sr, input int unsigned sc);
        wait_for_idle();
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_PAD_ROWS, pr);
        write_reg(REG_PAD_COLS, pc);
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kc);
        write_reg(REG_STRIDE_ROWS, sr);
        write_reg(REG_STRIDE_COLS, sc);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_element(input logic [BATCH_W-1:0] b, input logic [CHAN_W-1:0] ch,
                                input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                                input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_batch_index   <= b;
        i_channel_index <= ch;
        i_padded_row    <= r;
        i_padded_col    <= c;
        i_pixel_bits    <= pix;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_scatter(b, ch, r, c, pix);
    endtask

    // mostly inside the padded image, sometimes anywhere in the index range
    task automatic send_random_element();
        int unsigned ph, pw;
        logic [DIM_W-1:0] r, c;
        ph = clip(cfg_height, MAX_DIM) + 2 * cfg_pad_rows;
        pw = clip(cfg_width, MAX_DIM) + 2 * cfg_pad_cols;
        if ($urandom_range(99) < 80 && ph != 0 && pw != 0) begin
            r = DIM_W'($urandom_range(ph - 1, 0));
            c = DIM_W'($urandom_range(pw - 1, 0));
        end else begin
            r = DIM_W'($urandom_range(8191, 0));
            c = DIM_W'($urandom_range(8191, 0));
        end
        send_element(BATCH_W'($urandom_range(255, 0)), CHAN_W'($urandom_range(1023, 0)),
                     r, c, $urandom);
    endtask

    // reset geometry: 1x1 image, 1x1 kernel
    task automatic test_default_geometry();
        send_element(8'd0, 10'd0, 13'd0, 13'd0, 32'h3F80_0000);
        send_element(8'd1, 10'd2, 13'd1, 13'd0, 32'h1234_5678);
    endtask

    // pad corners, image corners, uncovered and out-of-range elements
    task automatic test_padded_border();
        set_geometry(5, 6, 1, 2, 3, 3, 1, 2);
        send_element(8'd0, 10'd0, 13'd0, 13'd0, 32'hFFFF_FFFF);
        send_element(8'd3, 10'd5, 13'd6, 13'd9, 32'hDEAD_BEEF);
        send_element(8'd7, 10'd9, 13'd3, 13'd5, 32'h4040_0000);
        send_element(8'd255, 10'd1023, 13'd1, 13'd2, 32'hFFFF_FFFF);
        send_element(8'd0, 10'd0, 13'd5, 13'd7, 32'h0000_0000);
        send_element(8'd12, 10'd34, 13'd0, 13'd4, 32'h8000_0001);
        send_element(8'd13, 10'd35, 13'd7, 13'd0, 32'h5555_5555);
        send_element(8'd255, 10'd1023, 13'd8191, 13'd8191, 32'hAAAA_AAAA);
        send_element(8'd14, 10'd36, 13'd3, 13'd8191, 32'h0F0F_0F0F);
    endtask

    // oversized registers saturate; full fan-out and position wrap
    task automatic test_max_geometry();
        set_geometry(8191, 8191, 15, 15, 15, 15, 1, 1);
        send_element(8'd200, 10'd600, 13'd2000, 13'd2000, 32'h7F7F_FFFF);
        send_element(8'd201, 10'd601, 13'd4125, 13'd4125, 32'hC000_0000);
        send_element(8'd202, 10'd602, 13'd0, 13'd0, 32'h3333_3333);
        set_geometry(4096, 4096, 0, 0, 8, 8, 15, 15);
        send_element(8'd203, 10'd603, 13'd30, 13'd45, 32'h6666_6666);
    endtask

    // zero kernel, zero stride, kernel over the image, all-pad rows
    task automatic test_degenerate_geometry();
        set_geometry(3, 3, 0, 0, 0, 2, 1, 1);
        send_element(8'd10, 10'd20, 13'd1, 13'd1, 32'h1111_1111);
        set_geometry(3, 3, 1, 1, 2, 2, 0, 0);
        send_element(8'd11, 10'd21, 13'd2, 13'd2, 32'h2222_2222);
        set_geometry(1, 1, 0, 0, 3, 3, 1, 1);
        send_element(8'd12, 10'd22, 13'd0, 13'd0, 32'h4444_4444);
        set_geometry(0, 2, 1, 1, 1, 1, 1, 1);
        send_element(8'd13, 10'd23, 13'd1, 13'd1, 32'h8888_8888);
    endtask

    // long receiver hold-off with a busy sender, then paced requests
    task automatic test_backpressure();
        int i;
        set_geometry(8, 8, 1, 1, 4, 4, 1, 1);
        send_gap_pct = 0;
        hold_token <= ~hold_token;
        for (i = 0; i < 12; i++) send_random_element();
        send_gap_pct = 36;
        for (i = 0; i < 4; i++) begin
            wait_for_idle();
            send_random_element();
        end
    endtask

    // random geometries, one burst of random requests each
    task automatic test_random_traffic();
        int phase, i, base;
        base = coords_seen;
        for (phase = 0; phase < 8 || (coords_seen - base < 48 && phase < 20); phase++) begin
            if ($urandom_range(5) == 0) begin
                set_geometry($urandom_range(8191, 0), $urandom_range(8191, 0),
                             $urandom_range(15, 0), $urandom_range(15, 0),
                             $urandom_range(15, 0), $urandom_range(15, 0),
                             $urandom_range(15, 0), $urandom_range(15, 0));
            end else begin
                set_geometry($urandom_range(20, 1), $urandom_range(20, 1),
                             $urandom_range(3, 0), $urandom_range(3, 0),
                             $urandom_range(8, 1), $urandom_range(8, 1),
                             $urandom_range(4, 1), $urandom_range(4, 1));
            end
            // one phase runs with no idling on either side
            if (phase == 3) begin
                send_gap_pct = 0;
                ready_gap_pct <= 0;
            end else begin
                send_gap_pct = 36;
                ready_gap_pct <= 36;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++) send_random_element();
        end
        send_gap_pct = 36;
        ready_gap_pct <= 36;
    endtask

    // receiver: random idling, or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= ready_gap_pct);
        end
    end

    // compare each coordinate against the oldest prediction
    always @(posedge i_clk) begin : check_coord
        t_coord want;
        if (i_rst_n && o_valid && i_ready) begin
            coords_seen++;
            if (expected_coords.size() == 0) begin
                report_mismatch("unexpected coordinate", o_window_position, 0);
            end else begin
                want = expected_coords.pop_front();
                if (o_out_batch !== want.batch)
                    report_mismatch("out_batch", o_out_batch, want.batch);
                if (o_out_channel !== want.channel)
                    report_mismatch("out_channel", o_out_channel, want.channel);
                if (o_kernel_offset !== want.kernel_offset)
                    report_mismatch("kernel_offset", o_kernel_offset, want.kernel_offset);
                if (o_window_position !== want.window_position)
                    report_mismatch("window_position", o_window_position,
                                    want.window_position);
                if (o_element_bits !== want.element_bits)
                    report_mismatch("element_bits", o_element_bits, want.element_bits);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_geometry();
        test_padded_border();
        test_max_geometry();
        test_degenerate_geometry();
        test_backpressure();
        test_random_traffic();
        wait_for_idle();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/isig_pkg.sv
hdl/isig_div.sv
hdl/isig_ctrl.sv
hdl/isig_dp.sv
hdl/im2col_scatter_index_generator.sv
hdl/isig_checker.sv
tb/sv/im2col_scatter_index_generator_test.sv
